// ----- design/cvq_pkg.sv -----
`timescale 1ns / 1ps

package cvq_pkg;

    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 8;
    localparam int LEVEL_W  = 9;
    localparam int STEP_W   = 13;
    localparam int GUARD_W  = 12;
    localparam int TARGET_W = LEVEL_W + STEP_W;
    localparam int DIV_CNT_W = 4;

    localparam logic [STEP_W-1:0]    FULL_SCALE   = 13'd4096;
    localparam logic [SAMPLE_W-1:0]  TOP_SAMPLE   = 12'hFFF;
    localparam logic [COUNT_W-1:0]   COUNT_RESET  = 8'd16;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = 4'd13;
    localparam logic [14:0]          THIRD_RECIP  = 15'd21846;

    typedef struct packed {
        logic cap_sample;
        logic div_start_step;
        logic div_start_quant;
        logic step_load;
        logic eval_load;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic need_quant;
        logic out_space;
    } t_status;

endpackage

// ----- design/cvq_in_if.sv -----
`timescale 1ns / 1ps

interface cvq_in_if;
    import cvq_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] cv_sample;

    modport source (output valid, output cv_sample, input ready);
    modport sink   (input valid, input cv_sample, output ready);
endinterface

// ----- design/cvq_out_if.sv -----
`timescale 1ns / 1ps

interface cvq_out_if;
    import cvq_pkg::*;

    logic               valid;
    logic               ready;
    logic               changed;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, output changed, output level, input ready);
    modport sink   (input valid, input changed, input level, output ready);
endinterface

// ----- design/cvq_ctrl.sv -----
`timescale 1ns / 1ps

module cvq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_cfg_we,
    input  cvq_pkg::t_status i_status,
    output cvq_pkg::t_cmd    o_cmd
);
    import cvq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SDIV  = 6'b000010,
        S_GUARD = 6'b000100,
        S_EVAL  = 6'b001000,
        S_QDIV  = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_dirty, n_dirty;

    always_comb begin
        n_state    = r_state;
        n_dirty    = r_dirty;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_sample = 1'b1;
                    if (r_dirty) begin
                        o_cmd.div_start_step = 1'b1;
                        n_state = S_SDIV;
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_SDIV: begin
                if (i_status.div_last) begin
                    n_state = S_GUARD;
                end
            end
            S_GUARD: begin
                o_cmd.step_load = 1'b1;
                n_dirty = 1'b0;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval_load = 1'b1;
                if (i_status.need_quant) begin
                    o_cmd.div_start_quant = 1'b1;
                    n_state = S_QDIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_QDIV: begin
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_status.out_space) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_dirty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dirty <= 1'b1;
        end else begin
            r_state <= n_state;
            r_dirty <= n_dirty;
        end
    end

endmodule

// ----- design/cvq_datapath.sv -----
`timescale 1ns / 1ps

module cvq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cvq_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic [cvq_pkg::SAMPLE_W-1:0]  i_cv_sample,
    input  cvq_pkg::t_cmd                 i_cmd,
    output cvq_pkg::t_status              o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic                          o_out_changed,
    output logic [cvq_pkg::LEVEL_W-1:0]   o_out_level
);
    import cvq_pkg::*;

    logic [COUNT_W-1:0]   r_step_count;
    logic [SAMPLE_W-1:0]  r_sample;
    logic [STEP_W-1:0]    r_step;
    logic [GUARD_W-1:0]   r_guard;
    logic [LEVEL_W-1:0]   r_held;
    logic                 r_upd;
    logic                 r_endpt;
    logic [STEP_W-1:0]    r_rem;
    logic [STEP_W-1:0]    r_quo;
    logic [STEP_W-1:0]    r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic                 r_out_changed;
    logic [LEVEL_W-1:0]   r_out_level;

    logic [COUNT_W-1:0]  w_steps;
    logic [STEP_W:0]     w_shift;
    logic                w_fits;
    logic [28:0]         w_gprod;
    logic [GUARD_W-1:0]  w_guard;
    logic [TARGET_W-1:0] w_target;
    logic [TARGET_W-1:0] w_samp;
    logic [TARGET_W-1:0] w_dist;
    logic                w_endpt;
    logic                w_over;
    logic [STEP_W-1:0]   w_qdividend;
    logic [LEVEL_W-1:0]  w_q;

    assign w_steps = (r_step_count == '0) ? COUNT_W'(1) : r_step_count;

    assign w_shift = {r_rem, r_quo[STEP_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_dvs});

    assign w_gprod = 29'({r_quo, 1'b0}) * 29'(THIRD_RECIP);
    assign w_guard = (w_gprod[27:16] == '0) ? GUARD_W'(1) : w_gprod[27:16];

    assign w_target = TARGET_W'(r_held) * TARGET_W'(r_step);
    assign w_samp   = TARGET_W'(r_sample);
    assign w_dist   = (w_target >= w_samp) ? (w_target - w_samp) : (w_samp - w_target);
    assign w_endpt  = (r_sample == '0) || (r_sample == TOP_SAMPLE);
    assign w_over   = (w_dist > TARGET_W'(r_guard));

    assign w_qdividend = STEP_W'(r_sample) + STEP_W'(r_step[STEP_W-1:1]);
    assign w_q         = r_quo[LEVEL_W-1:0];

    assign o_status.div_last   = (r_cnt == DIV_CNT_W'(1));
    assign o_status.need_quant = w_endpt || w_over;
    assign o_status.out_space  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_step_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_sample) begin
            r_sample <= i_cv_sample;
        end
        if (i_cmd.step_load) begin
            r_step  <= r_quo;
            r_guard <= w_guard;
        end
        if (i_cmd.eval_load) begin
            r_upd   <= w_endpt || w_over;
            r_endpt <= w_endpt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start_step || i_cmd.div_start_quant) begin
            r_cnt <= DIV_STEPS;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start_step) begin
            r_rem <= '0;
            r_quo <= FULL_SCALE;
            r_dvs <= STEP_W'(w_steps);
        end else if (i_cmd.div_start_quant) begin
            r_rem <= '0;
            r_quo <= w_qdividend;
            r_dvs <= r_step;
        end else if (r_cnt != '0) begin
            if (w_fits) begin
                r_rem <= STEP_W'(w_shift - {1'b0, r_dvs});
                r_quo <= {r_quo[STEP_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[STEP_W-1:0];
                r_quo <= {r_quo[STEP_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_upd) begin
                r_held <= w_q;
            end
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_level   <= r_upd ? w_q : r_held;
            r_out_changed <= r_upd && (!r_endpt || (w_q != r_held));
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_changed = r_out_changed;
    assign o_out_level   = r_out_level;

endmodule

// ----- design/cv_quantizer_with_guard_band.sv -----
`timescale 1ns / 1ps

// channel   dir  transfer when           payload
// i_in      in   valid && ready          cv_sample[11:0]
// o_out     out  valid && ready          changed, level[8:0]
// i_cfg_*   in   i_cfg_we                step_count[7:0]
//
// A sample that needs re-quantizing passes through accept, evaluate, the
// shared restoring divider and commit; any other skips the divider. The
// first sample after reset or a step_count write also passes through the
// step-size division and guard band. Reset is synchronous; the held level
// clears to zero. A stalled output holds its result while the next sample
// is accepted; commit waits only at the output register.

module cv_quantizer_with_guard_band (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cvq_in_if.sink                       i_in,
    cvq_out_if.source                    o_out,
    input  logic                         i_cfg_we,
    input  logic [cvq_pkg::COUNT_W-1:0]  i_cfg_data
);
    import cvq_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    cvq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    cvq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_cv_sample   (i_in.cv_sample),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_changed (o_out.changed),
        .o_out_level   (o_out.level)
    );

    assign i_in.ready = w_in_ready;

`ifndef NO_ASSERTIONS
    a_commit_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_status.out_space)
        else $error("commit without output space");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second sample accepted while one is in flight");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> o_out.valid)
        else $error("committed result not presented");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.commit && (w_cmd.div_start_quant || w_cmd.div_start_step)))
        else $error("commit overlaps divider start");
`endif

endmodule
